// ----- hdl/assert_macros.svh -----
// Assertion macros used by the RTL core of the Julian date converter.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STJD_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STJD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/stjd_pkg.sv -----
// Package of the seconds-to-Julian-date converter: field widths, reciprocal
// constants for the divisions by constants, and the cumulative month table.
// No dependencies.
package stjd_pkg;

    localparam int SECS_W  = 40;
    localparam int YEAR_W  = 15;
    localparam int YDAY_W  = 9;

    // Bias that makes any 40-bit timestamp non-negative; a multiple of 86400.
    localparam logic [40:0] SECS_BIAS = 41'd549755856000;

    // 86400 = 128 * 675. Division by 675 is done as a two-digit long division.
    localparam logic [17:0] RCP675_HI   = 18'd198842;     // ceil(2^27 / 675)
    localparam int          SH675_HI    = 27;
    localparam logic [26:0] RCP675_LO   = 27'd101806633;  // ceil(2^36 / 675)
    localparam int          SH675_LO    = 36;
    localparam logic [16:0] DIV675      = 17'd675;

    // Day count after the bias is removed and rebased to Julian -9999-01-01.
    localparam logic [25:0] DAY_SHIFT   = 26'd1991251;
    localparam logic [24:0] DAY_LAST    = 25'd7304633;    // Dec 31 of year 9999

    localparam logic [22:0] RCP1461     = 23'd5879490;    // ceil(2^33 / 1461)
    localparam int          SH1461      = 33;
    localparam logic [22:0] CYCLE_DAYS  = 23'd1461;
    localparam logic [23:0] RCP7        = 24'd9586981;    // ceil(2^26 / 7)
    localparam int          SH7         = 26;
    localparam logic [18:0] RCP60       = 19'd279621;     // ceil(2^24 / 60)
    localparam int          SH60        = 24;
    localparam logic [16:0] RCP3600     = 17'd74566;      // ceil(2^28 / 3600)
    localparam int          SH3600      = 28;

    localparam logic [10:0] YEAR_DAYS   = 11'd365;
    localparam logic [15:0] YEAR_REBASE = 16'd9999;
    localparam logic [3:0]  MONTHS      = 4'd12;

    // First day of year of each month; leap years add one from March on.
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] mon);
        logic [8:0] base;
        begin
            unique case (mon)
                4'd0:    base = 9'd0;
                4'd1:    base = 9'd31;
                4'd2:    base = 9'd59;
                4'd3:    base = 9'd90;
                4'd4:    base = 9'd120;
                4'd5:    base = 9'd151;
                4'd6:    base = 9'd181;
                4'd7:    base = 9'd212;
                4'd8:    base = 9'd243;
                4'd9:    base = 9'd273;
                4'd10:   base = 9'd304;
                4'd11:   base = 9'd334;
                default: base = 9'd0;
            endcase
            month_start = base + 9'((leap && (mon >= 4'd2)) ? 1 : 0);
        end
    endfunction

endpackage

// ----- hdl/stjd_stamp_if.sv -----
// Timestamp channel of the Julian date converter: valid/ready plus one
// signed seconds count. Depends on stjd_pkg for the field width.
interface stjd_stamp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [stjd_pkg::SECS_W-1:0]    unix_seconds;

    modport source (output valid, output unix_seconds, input ready);
    modport sink   (input valid, input unix_seconds, output ready);
endinterface

// ----- hdl/stjd_date_if.sv -----
// Date channel of the Julian date converter: valid/ready plus the broken-down
// date and time fields. Depends on stjd_pkg for the field widths.
interface stjd_date_if;
    logic                                  valid;
    logic                                  ready;
    logic        [5:0]                     second;
    logic        [5:0]                     minute;
    logic        [4:0]                     hour;
    logic signed [stjd_pkg::YEAR_W-1:0]    year;
    logic        [3:0]                     month;
    logic        [4:0]                     day_of_month;
    logic        [stjd_pkg::YDAY_W-1:0]    day_of_year;
    logic        [2:0]                     weekday;
    logic                                  out_of_range;

    modport source (output valid, output second, output minute, output hour, output year,
                    output month, output day_of_month, output day_of_year,
                    output weekday, output out_of_range, input ready);
    modport sink   (input valid, input second, input minute, input hour, input year,
                    input month, input day_of_month, input day_of_year,
                    input weekday, input out_of_range, output ready);
endinterface

// ----- hdl/seconds_to_julian_date_core.sv -----
// Top level of the seconds-to-Julian-date converter: a nine-register pipeline.
// Depends on stjd_pkg, stjd_stamp_if, stjd_date_if and assert_macros.svh.
//
// Usage
// -----
// The stamp channel takes one signed 40-bit Unix timestamp per beat. The
// date channel returns one beat per timestamp with second, minute, hour,
// proleptic Julian year, month, day of month, day of year, weekday and an
// out-of-range flag. When the flag is set the date fields read zero and the
// time-of-day fields still hold the floored time of day.
// Throughput: one beat per cycle while the receiver does not stall, set by
// the pipeline of nine registers (input register, seven work stages, output
// register), each with at most one multiply or one narrow compare chain on
// any path.
// When the receiver stalls with a result waiting, every stage holds and the
// stamp channel drops ready in the same cycle; bubbles are not squeezed out.
// Reset clears every stage's valid bit; payload registers are not reset.
`include "assert_macros.svh"

module seconds_to_julian_date_core (
    input  logic                clk,
    input  logic                rst_n,
    stjd_stamp_if.sink          stamp,
    stjd_date_if.source         date
);

    localparam int STAGES = 9;

    // Pipeline enable: everything advances unless a result is held back.
    logic               adv;
    logic [STAGES-1:0]  vld_reg;

    assign adv         = !vld_reg[STAGES-1] || date.ready;
    assign stamp.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], stamp.valid};
        end
    end

    // Stage 0: input register.
    logic [39:0] secs_reg;

    // Stage 1: bias the timestamp so it is non-negative, drop the factor 128
    // of 86400, and start the division by 675 on the high digit.
    logic [40:0] biased;
    logic [34:0] p_hi_next,  p_hi_reg;
    logic [16:0] v_hi_next,  v_hi_reg;
    logic [16:0] v_lo_next,  v_lo_reg;
    logic [6:0]  lo7_next,   lo7_1_reg;

    always_comb
    begin
        biased    = {secs_reg[39], secs_reg} + stjd_pkg::SECS_BIAS;
        lo7_next  = biased[6:0];
        v_hi_next = biased[40:24];
        v_lo_next = biased[23:7];
        p_hi_next = 35'(v_hi_next) * 35'(stjd_pkg::RCP675_HI);
    end

    // Stage 2: high quotient digit and its remainder.
    logic [7:0]  q_hi_next,  q_hi_2_reg;
    logic [9:0]  r_hi_next,  r_hi_reg;
    logic [16:0] v_lo_2_reg;
    logic [6:0]  lo7_2_reg;

    always_comb
    begin
        q_hi_next = p_hi_reg[stjd_pkg::SH675_HI +: 8];
        r_hi_next = 10'(v_hi_reg - 17'(q_hi_next) * stjd_pkg::DIV675);
    end

    // Stage 3: low digit of the long division, remainder shifted in.
    logic [26:0] x_lo_next,  x_lo_reg;
    logic [53:0] p_lo_next,  p_lo_reg;
    logic [7:0]  q_hi_3_reg;
    logic [6:0]  lo7_3_reg;

    always_comb
    begin
        x_lo_next = {r_hi_reg, v_lo_2_reg};
        p_lo_next = 54'(x_lo_next) * 54'(stjd_pkg::RCP675_LO);
    end

    // Stage 4: full day quotient and the seconds within the day.
    logic [16:0] q_lo;
    logic [24:0] dq_next,    dq_reg;
    logic [16:0] tod_next,   tod_4_reg;

    always_comb
    begin
        q_lo     = p_lo_reg[stjd_pkg::SH675_LO +: 17];
        dq_next  = {q_hi_3_reg, q_lo};
        tod_next = {10'(x_lo_reg - 27'(q_lo) * 27'(stjd_pkg::DIV675)), lo7_3_reg};
    end

    // Stage 5: rebase the day count, range check, and the four reciprocal
    // multiplies for the cycle split, the weekday and the time of day.
    logic [25:0] days;
    logic        oor_next,   oor_5_reg;
    logic [22:0] d23_next,   d23_reg;
    logic [23:0] d1_next,    d1_reg;
    logic [45:0] p_cyc_next, p_cyc_reg;
    logic [47:0] p_wk_next,  p_wk_reg;
    logic [35:0] p_mt_next,  p_mt_reg;
    logic [33:0] p_hr_next,  p_hr_reg;
    logic [16:0] tod_5_reg;

    always_comb
    begin
        days       = {1'b0, dq_reg} - stjd_pkg::DAY_SHIFT;
        oor_next   = days[25] || (days[24:0] > stjd_pkg::DAY_LAST);
        d23_next   = days[22:0];
        d1_next    = 24'(d23_next) + 24'd1;
        p_cyc_next = 46'(d23_next) * 46'(stjd_pkg::RCP1461);
        p_wk_next  = 48'(d1_next) * 48'(stjd_pkg::RCP7);
        p_mt_next  = 36'(tod_4_reg) * 36'(stjd_pkg::RCP60);
        p_hr_next  = 34'(tod_4_reg) * 34'(stjd_pkg::RCP3600);
    end

    // Stage 6: quotients become cycle index, day in cycle, weekday and clock.
    logic [12:0] y4_next,    y4_reg;
    logic [20:0] wq;
    logic [10:0] mt;
    logic [10:0] tmp_next,   tmp_reg;
    logic [2:0]  wday_next,  wday_6_reg, wday_7_reg;
    logic [5:0]  sec_next,   sec_6_reg,  sec_7_reg;
    logic [5:0]  min_next,   min_6_reg,  min_7_reg;
    logic [4:0]  hr_next,    hr_6_reg,   hr_7_reg;
    logic        oor_6_reg,  oor_7_reg;

    always_comb
    begin
        y4_next   = p_cyc_reg[stjd_pkg::SH1461 +: 13];
        wq        = p_wk_reg[stjd_pkg::SH7 +: 21];
        mt        = p_mt_reg[stjd_pkg::SH60 +: 11];
        hr_next   = p_hr_reg[stjd_pkg::SH3600 +: 5];
        tmp_next  = 11'(d23_reg - 23'(y4_next) * stjd_pkg::CYCLE_DAYS);
        wday_next = 3'(d1_reg - 24'(wq) * 24'd7);
        sec_next  = 6'(tod_5_reg - 17'(mt) * 17'd60);
        min_next  = 6'(mt - 11'(hr_next) * 11'd60);
    end

    // Stage 7: year within the cycle (the last day of the leap year stays in
    // year three), day of year and the astronomical year number.
    logic [1:0]  yi;
    logic [8:0]  yday_next,  yday_reg;
    logic        leap_next,  leap_reg;
    logic [14:0] year_next,  year_reg;

    always_comb
    begin
        priority if (tmp_reg >= 11'd1095)
        begin
            yi = 2'd3;
        end
        else if (tmp_reg >= 11'd730)
        begin
            yi = 2'd2;
        end
        else if (tmp_reg >= stjd_pkg::YEAR_DAYS)
        begin
            yi = 2'd1;
        end
        else
        begin
            yi = 2'd0;
        end
        yday_next = 9'(tmp_reg - 11'(yi) * stjd_pkg::YEAR_DAYS);
        leap_next = (yi == 2'd3);
        year_next = 15'({1'b0, y4_reg, yi} - stjd_pkg::YEAR_REBASE);
    end

    // Stage 8: month search over the cumulative table, then the output
    // register. Out-of-range dates clear the calendar fields.
    logic [3:0]  mon;
    logic [8:0]  mstart;

    always_comb
    begin
        mon = 4'd0;
        for (int m = 1; m < 12; m++)
        begin
            if (yday_reg >= stjd_pkg::month_start(leap_reg, 4'(m)))
            begin
                mon = mon + 4'd1;
            end
        end
        mstart = stjd_pkg::month_start(leap_reg, mon);
    end

    logic [5:0]  out_sec_reg;
    logic [5:0]  out_min_reg;
    logic [4:0]  out_hr_reg;
    logic [14:0] out_year_reg;
    logic [3:0]  out_mon_reg;
    logic [4:0]  out_mday_reg;
    logic [8:0]  out_yday_reg;
    logic [2:0]  out_wday_reg;
    logic        out_oor_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            secs_reg     <= stamp.unix_seconds;

            p_hi_reg     <= p_hi_next;
            v_hi_reg     <= v_hi_next;
            v_lo_reg     <= v_lo_next;
            lo7_1_reg    <= lo7_next;

            q_hi_2_reg   <= q_hi_next;
            r_hi_reg     <= r_hi_next;
            v_lo_2_reg   <= v_lo_reg;
            lo7_2_reg    <= lo7_1_reg;

            x_lo_reg     <= x_lo_next;
            p_lo_reg     <= p_lo_next;
            q_hi_3_reg   <= q_hi_2_reg;
            lo7_3_reg    <= lo7_2_reg;

            dq_reg       <= dq_next;
            tod_4_reg    <= tod_next;

            oor_5_reg    <= oor_next;
            d23_reg      <= d23_next;
            d1_reg       <= d1_next;
            p_cyc_reg    <= p_cyc_next;
            p_wk_reg     <= p_wk_next;
            p_mt_reg     <= p_mt_next;
            p_hr_reg     <= p_hr_next;
            tod_5_reg    <= tod_4_reg;

            y4_reg       <= y4_next;
            tmp_reg      <= tmp_next;
            wday_6_reg   <= wday_next;
            sec_6_reg    <= sec_next;
            min_6_reg    <= min_next;
            hr_6_reg     <= hr_next;
            oor_6_reg    <= oor_5_reg;

            yday_reg     <= yday_next;
            leap_reg     <= leap_next;
            year_reg     <= year_next;
            wday_7_reg   <= wday_6_reg;
            sec_7_reg    <= sec_6_reg;
            min_7_reg    <= min_6_reg;
            hr_7_reg     <= hr_6_reg;
            oor_7_reg    <= oor_6_reg;

            out_sec_reg  <= sec_7_reg;
            out_min_reg  <= min_7_reg;
            out_hr_reg   <= hr_7_reg;
            out_oor_reg  <= oor_7_reg;
            if (oor_7_reg)
            begin
                out_year_reg <= '0;
                out_mon_reg  <= '0;
                out_mday_reg <= '0;
                out_yday_reg <= '0;
                out_wday_reg <= '0;
            end
            else
            begin
                out_year_reg <= year_reg;
                out_mon_reg  <= mon;
                out_mday_reg <= 5'(yday_reg - mstart + 9'd1);
                out_yday_reg <= yday_reg;
                out_wday_reg <= wday_7_reg;
            end
        end
    end

    // Marks a stage-seven date that is the first day of its year.
    logic year_start;
    assign year_start = (yday_reg == 9'd0);

    assign date.valid        = vld_reg[STAGES-1];
    assign date.second       = out_sec_reg;
    assign date.minute       = out_min_reg;
    assign date.hour         = out_hr_reg;
    assign date.year         = $signed(out_year_reg);
    assign date.month        = out_mon_reg;
    assign date.day_of_month = out_mday_reg;
    assign date.day_of_year  = out_yday_reg;
    assign date.weekday      = out_wday_reg;
    assign date.out_of_range = out_oor_reg;

    // Out-of-range results carry no calendar date.
    `STJD_ASSERT(a_oor_zero, date.valid && date.out_of_range,
        (date.year == 15'sd0) && (date.month == 4'd0) && (date.day_of_year == 9'd0),
        "oor date not zero")
    // In January the day of year and the day of month agree.
    `STJD_ASSERT(a_jan_days, date.valid && !date.out_of_range && (date.month == 4'd0),
        date.day_of_year == 9'(date.day_of_month) - 9'd1, "January day mismatch")
    // A first day of the year lands in January on day one.
    `STJD_ASSERT_NEXT(a_new_year, adv && vld_reg[7] && !oor_7_reg && year_start,
        (date.month == 4'd0) && (date.day_of_month == 5'd1), "new year not Jan 1")
    // A held result freezes every stage.
    `STJD_ASSERT_NEXT(a_hold, !stamp.ready, $stable(vld_reg), "pipeline moved during stall")

endmodule

// ----- verif/seconds_to_julian_date_core_test.sv -----
// Self-checking testbench of seconds_to_julian_date_core: a timestamp driver,
// a date monitor and a calendar predictor that checks every result beat.
// Depends on stjd_pkg, stjd_stamp_if, stjd_date_if and the core itself.
module seconds_to_julian_date_core_test;

    // Calendar constants of the predictor. Day 0 is Julian -9999-01-01.
    localparam longint SECS_PER_DAY    = 86400;
    localparam longint DAY_OFFSET      = 4371664;
    localparam longint FIRST_YEAR      = 9999;
    localparam longint DAYS_IN_CYCLE   = 3 * 365 + 366;
    localparam longint LAST_YEAR_INDEX = 19998;
    localparam longint LAST_VALID_DAY  = 7304633;

    localparam int PIPE_LATENCY   = 8;
    localparam int RANDOM_ITEMS   = 1130;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRESSURE_AT    = 400;
    localparam int LONG_HOLD      = 300;

    // First day of year of each month, common year then leap year.
    localparam int MONTH_FIRST [2][12] = '{
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334},
        '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335}
    };

    // Offsets within a four-year cycle where the year or month split turns over:
    // starts and ends of each year, the end of February, and the leap day.
    localparam int CYCLE_MARKS [15] = '{
        0, 1, 58, 59, 364, 365, 729, 730, 1094, 1095, 1153, 1154, 1155, 1459, 1460
    };

    typedef struct packed {
        logic [stjd_pkg::SECS_W-1:0] stamp;
        logic [5:0]                  second;
        logic [5:0]                  minute;
        logic [4:0]                  hour;
        logic [stjd_pkg::YEAR_W-1:0] year;
        logic [3:0]                  month;
        logic [4:0]                  day_of_month;
        logic [stjd_pkg::YDAY_W-1:0] day_of_year;
        logic [2:0]                  weekday;
        logic                        out_of_range;
    } julian_date_t;

    // The clock starts low and reset is low from the very first instant, so the
    // reset branches below see no spurious edge at time zero.
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    stjd_stamp_if stamp_ch();
    stjd_date_if  date_ch();

    seconds_to_julian_date_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .stamp (stamp_ch),
        .date  (date_ch)
    );

    logic [stjd_pkg::SECS_W-1:0] pending_stamps [$];
    julian_date_t                expected_dates [$];
    julian_date_t                oldest_date;

    int  error_count = 0;
    int  results_seen = 0;
    int  quiet_cycles = 0;
    int  send_gap = 0;
    int  ready_hold = 0;
    bit  sender_burst = 1'b0;
    bit  receiver_burst = 1'b0;

    // Breaks one timestamp into the Julian date and time of day. Both the time
    // of day and the day count are floored, so negative stamps still give a
    // valid time of day. Dates outside years -9999..9999 give only the time of
    // day and the out-of-range flag; the date fields stay zero.
    function automatic julian_date_t julian_breakdown(
        input logic signed [stjd_pkg::SECS_W-1:0] stamp);
        julian_date_t d;
        longint       secs;
        longint       tod;
        longint       days;
        longint       cycle;
        longint       day_in_cycle;
        longint       year_in_cycle;
        longint       yday;
        longint       year_index;
        int           mon;
        bit           leap;
        begin
            d = '0;
            d.stamp = stamp;
            d.out_of_range = 1'b1;
            secs = longint'(stamp);
            tod = secs % SECS_PER_DAY;
            if (tod < 0)
                tod += SECS_PER_DAY;
            days = (secs - tod) / SECS_PER_DAY + DAY_OFFSET;
            d.second = 6'(tod % 60);
            d.minute = 6'((tod % 3600) / 60);
            d.hour = 5'(tod / 3600);
            if (days >= 0)
            begin
                cycle = days / DAYS_IN_CYCLE;
                day_in_cycle = days % DAYS_IN_CYCLE;
                // The last day of the leap year would land on index 4; it
                // belongs to the leap year as its day 365.
                year_in_cycle = day_in_cycle / 365;
                if (year_in_cycle > 3)
                    year_in_cycle = 3;
                yday = day_in_cycle - 365 * year_in_cycle;
                year_index = 4 * cycle + year_in_cycle;
                if (year_index <= LAST_YEAR_INDEX)
                begin
                    leap = (year_in_cycle == 3);
                    mon = 11;
                    while (mon > 0 && MONTH_FIRST[leap][mon] > yday)
                        mon--;
                    d.year = 15'(year_index - FIRST_YEAR);
                    d.month = 4'(mon);
                    d.day_of_month = 5'(yday - MONTH_FIRST[leap][mon] + 1);
                    d.day_of_year = 9'(yday);
                    d.weekday = 3'((days + 1) % 7);
                    d.out_of_range = 1'b0;
                end
            end
            return d;
        end
    endfunction

    // Timestamp of a given time of day on a given day, counted from -9999-01-01.
    function automatic logic [stjd_pkg::SECS_W-1:0] stamp_at(input longint day,
                                                              input longint tod);
        longint secs;
        begin
            secs = (day - DAY_OFFSET) * SECS_PER_DAY + tod;
            return secs[stjd_pkg::SECS_W-1:0];
        end
    endfunction

    // Compares one field of a result beat; X or Z on the result counts as wrong.
    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got,
                               input logic [stjd_pkg::SECS_W-1:0] stamp);
        begin
            if (want !== got)
            begin
                error_count++;
                $display("%0t: %s of stamp %0d: expected %0d, actual %0d",
                         $time, name, $signed(stamp), want, got);
            end
        end
    endtask

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // The stimulus is complete before the first clock edge. The directed part
    // walks the range limits, the turns into the second and fourth year of a
    // cycle, the leap day and the clamped last day of the leap year; the random
    // part is mostly in-range dates with a share of cycle turnovers, range edges
    // and raw 40-bit patterns so that every input bit toggles.
    initial
    begin
        int unsigned                 pick;
        longint                      day;
        logic [63:0]                 raw_bits;
        logic [stjd_pkg::SECS_W-1:0] stamp;

        pending_stamps.push_back('0);
        pending_stamps.push_back('1);
        pending_stamps.push_back({1'b0, {(stjd_pkg::SECS_W-1){1'b1}}});
        pending_stamps.push_back({1'b1, {(stjd_pkg::SECS_W-1){1'b0}}});
        pending_stamps.push_back(stamp_at(DAY_OFFSET - 2, 86399));
        pending_stamps.push_back(stamp_at(0, 0));
        pending_stamps.push_back(stamp_at(0, 0) - 1);
        pending_stamps.push_back(stamp_at(LAST_VALID_DAY, 86399));
        pending_stamps.push_back(stamp_at(LAST_VALID_DAY, 86399) + 1);
        pending_stamps.push_back(stamp_at(58, 86399));
        pending_stamps.push_back(stamp_at(59, 0));
        pending_stamps.push_back(stamp_at(364, 86399));
        pending_stamps.push_back(stamp_at(365, 0));
        pending_stamps.push_back(stamp_at(1095, 0));
        pending_stamps.push_back(stamp_at(1154, 43261));
        pending_stamps.push_back(stamp_at(1155, 1));
        pending_stamps.push_back(stamp_at(1460, 43261));
        pending_stamps.push_back(stamp_at(1461, 0));
        pending_stamps.push_back(stamp_at(3652134 + 59, 12345));
        pending_stamps.push_back(stamp_at(4999 * 1461 + 1460, 3599));

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                stamp = stamp_at($urandom_range(0, LAST_VALID_DAY), $urandom_range(0, 86399));
            else if (pick < 75)
                stamp = stamp_at(longint'(1461 * $urandom_range(0, 4999))
                                 + CYCLE_MARKS[$urandom_range(0, 14)],
                                 $urandom_range(0, 86399));
            else if (pick < 85)
            begin
                day = longint'($urandom_range(0, 7)) - 4;
                if ($urandom_range(0, 1) == 1)
                    day += LAST_VALID_DAY;
                stamp = stamp_at(day, $urandom_range(0, 86399));
            end
            else
            begin
                raw_bits = {$urandom, $urandom};
                stamp = raw_bits[stjd_pkg::SECS_W-1:0];
            end
            pending_stamps.push_back(stamp);
        end

        while (pending_stamps.size() != 0 || stamp_ch.valid || expected_dates.size() != 0)
            @(negedge clk);
        // Anything that still comes out now is a beat nobody asked for.
        repeat (2 * PIPE_LATENCY) @(negedge clk);

        if (error_count == 0)
            $display("seconds_to_julian_date_core_test: PASS");
        else
            $display("seconds_to_julian_date_core_test: FAIL");
        $finish;
    end

    // Timestamp driver. A timestamp is predicted at the edge where its beat is
    // taken. After each beat the sender waits a drawn number of cycles, or none
    // at all while it is in a burst stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_ch.valid <= 1'b0;
            stamp_ch.unix_seconds <= '0;
            send_gap = 0;
        end
        else
        begin
            if (stamp_ch.valid && stamp_ch.ready)
                expected_dates.push_back(julian_breakdown(stamp_ch.unix_seconds));
            if (!stamp_ch.valid || stamp_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    stamp_ch.valid <= 1'b0;
                end
                else if (pending_stamps.size() != 0)
                begin
                    stamp_ch.valid <= 1'b1;
                    stamp_ch.unix_seconds <= pending_stamps.pop_front();
                    if ($urandom_range(0, 39) == 0)
                        sender_burst = !sender_burst;
                    send_gap = sender_burst ? 0 : $urandom_range(0, 9);
                end
                else
                    stamp_ch.valid <= 1'b0;
            end
        end
    end

    // Date monitor. Every result beat is checked against the oldest prediction.
    // After each beat the receiver holds ready low for a drawn number of cycles;
    // once, it holds off long enough for the pipeline to fill and push back on
    // the timestamp channel while the driver keeps offering beats.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            date_ch.ready <= 1'b0;
            ready_hold = 0;
        end
        else
        begin
            if (date_ch.valid && date_ch.ready)
            begin
                results_seen++;
                if (expected_dates.size() == 0)
                begin
                    error_count++;
                    $display("%0t: stray result beat: expected none, actual year %0d",
                             $time, date_ch.year);
                end
                else
                begin
                    oldest_date = expected_dates.pop_front();
                    check_field("second", oldest_date.second, date_ch.second, oldest_date.stamp);
                    check_field("minute", oldest_date.minute, date_ch.minute, oldest_date.stamp);
                    check_field("hour", oldest_date.hour, date_ch.hour, oldest_date.stamp);
                    check_field("year", $signed(oldest_date.year), date_ch.year,
                                oldest_date.stamp);
                    check_field("month", oldest_date.month, date_ch.month, oldest_date.stamp);
                    check_field("day_of_month", oldest_date.day_of_month,
                                date_ch.day_of_month, oldest_date.stamp);
                    check_field("day_of_year", oldest_date.day_of_year,
                                date_ch.day_of_year, oldest_date.stamp);
                    check_field("weekday", oldest_date.weekday, date_ch.weekday,
                                oldest_date.stamp);
                    check_field("out_of_range", oldest_date.out_of_range,
                                date_ch.out_of_range, oldest_date.stamp);
                end
                if ($urandom_range(0, 39) == 0)
                    receiver_burst = !receiver_burst;
                if (results_seen == PRESSURE_AT)
                    ready_hold = LONG_HOLD;
                else
                    ready_hold = receiver_burst ? 0 : $urandom_range(0, 9);
            end
            if ((date_ch.valid && date_ch.ready) || !date_ch.ready)
            begin
                if (ready_hold > 0)
                begin
                    ready_hold--;
                    date_ch.ready <= 1'b0;
                end
                else
                    date_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: too many cycles without a beat on either channel means the
    // block has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (stamp_ch.valid && stamp_ch.ready) || (date_ch.valid && date_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
            $display("seconds_to_julian_date_core_test: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
